FILE: hw/rtl/cog_pkg.sv
// Shared constants, register codes and the CORDIC arctangent table for the
// circle orbit guidance block. No dependencies.
`timescale 1ns / 1ps

package cog_pkg;

	// Configuration register indexes.
	localparam logic [7:0] CFG_TURN_RIGHT = 8'd0;
	localparam logic [7:0] CFG_RADIUS     = 8'd1;
	localparam logic [7:0] CFG_PERIOD     = 8'd2;
	localparam logic [7:0] CFG_BANK_LIM   = 8'd3;

	// Register reset values and floors.
	localparam int RADIUS_RST  = 1000;
	localparam int PERIOD_RST  = 2500;
	localparam int BANK_RST    = 2000;
	localparam int RADIUS_MIN  = 100;
	localparam int PERIOD_MIN  = 10;
	localparam int BANK_MIN    = 10;

	// Course arithmetic in centidegrees.
	localparam int COURSE_FULL = 36000;
	localparam logic signed [17:0] CRS_FULL = 18'sd36000;
	localparam logic signed [17:0] CRS_HALF = 18'sd18000;
	localparam logic signed [17:0] CRS_QTR  = 18'sd9000;

	// Scale factors.
	localparam int MAG_SCALE   = 9000;
	localparam int ACC_SCALE   = 1000;
	localparam int TTG_SCALE   = 100;
	localparam int SLOW_SPEED  = 10;
	localparam int TTG_MAX     = 1048575;
	localparam int SIN_X0      = 636751;
	localparam int L1_GAIN     = 8885766;
	localparam int GRAVITY_UM  = 9810000;
	localparam int ANG_ROUND   = 32768;

	// CORDIC angle format: 1/65536 centidegree.
	localparam int CORDIC_STEPS = 20;
	localparam int ANG_W        = 32;

	// Arctangent of 2^-i in CORDIC angle units.
	function automatic logic signed [ANG_W-1:0] cog_atan(input int i);
		logic signed [ANG_W-1:0] a;
		case (i)
			0:       a = 32'sd294912000;
			1:       a = 32'sd174096719;
			2:       a = 32'sd91987925;
			3:       a = 32'sd46694507;
			4:       a = 32'sd23437865;
			5:       a = 32'sd11730358;
			6:       a = 32'sd5866610;
			7:       a = 32'sd2933484;
			8:       a = 32'sd1466764;
			9:       a = 32'sd733385;
			10:      a = 32'sd366693;
			11:      a = 32'sd183346;
			12:      a = 32'sd91673;
			13:      a = 32'sd45837;
			14:      a = 32'sd22918;
			15:      a = 32'sd11459;
			16:      a = 32'sd5730;
			17:      a = 32'sd2865;
			18:      a = 32'sd1432;
			19:      a = 32'sd716;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: hw/rtl/circle_orbit_guidance.sv
// Top level of the circle orbit guidance pipeline.
// Depends on cog_pkg, cog_div and cog_cordic.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  input    | start / busy          | center_bearing, center_distance,
//           |                       | ground_track, ground_speed
//  result   | done (one-cycle)      | target_course, bank_cmd,
//           |                       | distance_out, time_to_go
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item may enter every cycle; busy is always low. A result passes through
// four restoring dividers (24, 32, 14 and 36 bit stages), two 20-stage
// CORDIC units and eight plain pipeline registers. Reset clears the valid
// bits and loads the register defaults. The result side cannot stall, so
// the pipeline advances every cycle.
`timescale 1ns / 1ps

module circle_orbit_guidance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] center_bearing,
	input  logic [19:0] center_distance,
	input  logic [15:0] ground_track,
	input  logic [13:0] ground_speed,
	output logic        done,
	output logic [15:0] target_course,
	output logic signed [14:0] bank_cmd,
	output logic [19:0] distance_out,
	output logic [19:0] time_to_go,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import cog_pkg::*;

	localparam int TTG_QW   = 24;
	localparam int IDEAL_QW = 32;
	localparam int MAG_QW   = 14;
	localparam int L1_QW    = 36;
	localparam int SIN_XW   = 24;
	localparam int VEC_XW   = 38;
	localparam int LATENCY  = 8 + 2 * CORDIC_STEPS + TTG_QW + IDEAL_QW + MAG_QW + L1_QW;

	typedef struct packed {
		logic [15:0] tgt0;
		logic [15:0] trk;
		logic [19:0] ctr_dist;
		logic [13:0] spd;
		logic        in_circle;
		logic        outside;
		logic        slow;
		logic [33:0] mag_num;
		logic [37:0] ideal_num;
	} sb_a_t;

	typedef struct packed {
		logic [15:0] tgt0;
		logic [15:0] trk;
		logic [19:0] ctr_dist;
		logic [13:0] spd;
		logic        in_circle;
		logic        outside;
		logic [33:0] mag_num;
		logic [19:0] ttg;
	} sb_b_t;

	typedef struct packed {
		logic [15:0] tgt0;
		logic [15:0] trk;
		logic [19:0] ctr_dist;
		logic [13:0] spd;
		logic        in_circle;
		logic        outside;
		logic [19:0] ttg;
		logic [31:0] ideal;
	} sb_c_t;

	typedef struct packed {
		logic [15:0] tgt;
		logic [19:0] ctr_dist;
		logic [19:0] ttg;
		logic [31:0] ideal;
		logic [13:0] spd;
	} sb_d_t;

	typedef struct packed {
		logic [15:0] tgt;
		logic [19:0] ctr_dist;
		logic [19:0] ttg;
		logic [31:0] ideal;
	} sb_e_t;

	typedef struct packed {
		logic  neg;
		sb_e_t e;
	} sb_f_t;

	typedef struct packed {
		logic [15:0] tgt;
		logic [19:0] ctr_dist;
		logic [19:0] ttg;
	} sb_g_t;

	// Wrap a course once so that it lands in 0..36000.
	function automatic logic signed [17:0] wrap_course(input logic signed [17:0] c);
		logic signed [17:0] w;
		w = c;
		if (w > CRS_FULL) w = w - CRS_FULL;
		if (w < 0) w = w + CRS_FULL;
		return w;
	endfunction

	// Configuration registers.
	logic        turn_right_q;
	logic [19:0] radius_q;
	logic [15:0] period_q;
	logic [13:0] bank_lim_q;
	logic [19:0] r_eff;
	logic [15:0] p_eff;
	logic [13:0] lim_eff;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_right_q <= 1'b0;
			radius_q     <= 20'(RADIUS_RST);
			period_q     <= 16'(PERIOD_RST);
			bank_lim_q   <= 14'(BANK_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TURN_RIGHT: turn_right_q <= cfg_data[0];
				CFG_RADIUS:     radius_q     <= cfg_data;
				CFG_PERIOD:     period_q     <= cfg_data[15:0];
				CFG_BANK_LIM:   bank_lim_q   <= cfg_data[13:0];
				default:        ;
			endcase
		end
	end

	// Effective values: radius clamps to its floor, others revert to reset.
	assign r_eff   = (radius_q < 20'(RADIUS_MIN)) ? 20'(RADIUS_MIN) : radius_q;
	assign p_eff   = (period_q < 16'(PERIOD_MIN)) ? 16'(PERIOD_RST) : period_q;
	assign lim_eff = (bank_lim_q < 14'(BANK_MIN)) ? 14'(BANK_RST) : bank_lim_q;

	// Stage 1: capture the input transaction.
	logic        vld_s1;
	logic [15:0] brg_s1;
	logic [19:0] dist_s1;
	logic [15:0] trk_s1;
	logic [13:0] spd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		brg_s1  <= center_bearing;
		dist_s1 <= center_distance;
		trk_s1  <= ground_track;
		spd_s1  <= ground_speed;
	end

	// Angle reduction and the radial error, clamped to one radius outside.
	logic [15:0] brg_m;
	logic [15:0] trk_m;
	logic        in_circle;
	logic        outside;
	logic [19:0] out_diff;
	logic [19:0] od;

	assign brg_m     = (brg_s1 >= 16'(COURSE_FULL)) ? brg_s1 - 16'(COURSE_FULL) : brg_s1;
	assign trk_m     = (trk_s1 >= 16'(COURSE_FULL)) ? trk_s1 - 16'(COURSE_FULL) : trk_s1;
	assign in_circle = dist_s1 < r_eff;
	assign outside   = dist_s1 > r_eff;
	assign out_diff  = dist_s1 - r_eff;
	assign od        = in_circle ? r_eff - dist_s1 : ((out_diff > r_eff) ? r_eff : out_diff);

	// Stage 2.
	logic        vld_s2;
	logic [15:0] brg_s2;
	logic [15:0] trk_s2;
	logic [19:0] dist_s2;
	logic [13:0] spd_s2;
	logic        in_circle_s2;
	logic        outside_s2;
	logic [19:0] od_s2;
	logic [27:0] vsq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		brg_s2       <= brg_m;
		trk_s2       <= trk_m;
		dist_s2      <= dist_s1;
		spd_s2       <= spd_s1;
		in_circle_s2 <= in_circle;
		outside_s2   <= outside;
		od_s2        <= od;
		vsq_s2       <= 28'(spd_s1) * 28'(spd_s1);
	end

	// Tangent course and the three dividend numerators.
	logic signed [17:0] tgt0;
	sb_a_t              sb_a_i;
	sb_a_t              sb_a_o;
	logic [26:0]        ttg_num;
	logic               ttg_vld;
	logic [TTG_QW-1:0]  ttg_quo;
	logic [19:0]        ttg_sat;

	assign tgt0 = wrap_course($signed({2'b00, brg_s2}) + (turn_right_q ? -CRS_QTR : CRS_QTR));

	assign ttg_num = 27'(dist_s2) * 27'(TTG_SCALE) + 27'(spd_s2 >> 1);

	always_comb begin
		sb_a_i.tgt0      = tgt0[15:0];
		sb_a_i.trk       = trk_s2;
		sb_a_i.ctr_dist  = dist_s2;
		sb_a_i.spd       = spd_s2;
		sb_a_i.in_circle = in_circle_s2;
		sb_a_i.outside   = outside_s2;
		sb_a_i.slow      = spd_s2 <= 14'(SLOW_SPEED);
		sb_a_i.mag_num   = 34'(od_s2) * 34'(MAG_SCALE) + 34'(r_eff >> 1);
		sb_a_i.ideal_num = 38'(vsq_s2) * 38'(ACC_SCALE);
	end

	// Time to go: rounded distance over speed.
	cog_div #(
		.NW(27), .DW(14), .QW(TTG_QW), .SW($bits(sb_a_t))
	) u_div_ttg (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.num     (ttg_num),
		.den     (spd_s2),
		.side_in (sb_a_i),
		.out_vld (ttg_vld),
		.quo     (ttg_quo),
		.side_out(sb_a_o)
	);

	assign ttg_sat = sb_a_o.slow ? '0 :
		((ttg_quo > TTG_QW'(TTG_MAX)) ? 20'(TTG_MAX) : ttg_quo[19:0]);

	// Centripetal acceleration magnitude V^2/R.
	sb_b_t               sb_b_i;
	sb_b_t               sb_b_o;
	logic                ideal_vld;
	logic [IDEAL_QW-1:0] ideal_quo;

	always_comb begin
		sb_b_i.tgt0      = sb_a_o.tgt0;
		sb_b_i.trk       = sb_a_o.trk;
		sb_b_i.ctr_dist  = sb_a_o.ctr_dist;
		sb_b_i.spd       = sb_a_o.spd;
		sb_b_i.in_circle = sb_a_o.in_circle;
		sb_b_i.outside   = sb_a_o.outside;
		sb_b_i.mag_num   = sb_a_o.mag_num;
		sb_b_i.ttg       = ttg_sat;
	end

	cog_div #(
		.NW(38), .DW(20), .QW(IDEAL_QW), .SW($bits(sb_b_t))
	) u_div_ideal (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (ttg_vld),
		.num     (sb_a_o.ideal_num),
		.den     (r_eff),
		.side_in (sb_b_i),
		.out_vld (ideal_vld),
		.quo     (ideal_quo),
		.side_out(sb_b_o)
	);

	// Course offset magnitude, rounded half up.
	sb_c_t             sb_c_i;
	sb_c_t             sb_c_o;
	logic              mag_vld;
	logic [MAG_QW-1:0] mag_quo;

	always_comb begin
		sb_c_i.tgt0      = sb_b_o.tgt0;
		sb_c_i.trk       = sb_b_o.trk;
		sb_c_i.ctr_dist  = sb_b_o.ctr_dist;
		sb_c_i.spd       = sb_b_o.spd;
		sb_c_i.in_circle = sb_b_o.in_circle;
		sb_c_i.outside   = sb_b_o.outside;
		sb_c_i.ttg       = sb_b_o.ttg;
		sb_c_i.ideal     = ideal_quo;
	end

	cog_div #(
		.NW(34), .DW(20), .QW(MAG_QW), .SW($bits(sb_c_t))
	) u_div_mag (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (ideal_vld),
		.num     (sb_b_o.mag_num),
		.den     (r_eff),
		.side_in (sb_c_i),
		.out_vld (mag_vld),
		.quo     (mag_quo),
		.side_out(sb_c_o)
	);

	// Bend the course in or out, then form the wrapped course error.
	logic               bend_plus;
	logic signed [17:0] delta;
	logic signed [17:0] tgt1;
	logic signed [17:0] err_raw;
	logic signed [17:0] err;

	assign bend_plus = sb_c_o.in_circle ? !turn_right_q : turn_right_q;
	assign delta     = bend_plus ? 18'(mag_quo) : -18'(mag_quo);
	assign tgt1      = (sb_c_o.in_circle || sb_c_o.outside) ?
		wrap_course($signed({2'b00, sb_c_o.tgt0}) + delta) : $signed({2'b00, sb_c_o.tgt0});
	assign err_raw   = $signed({2'b00, sb_c_o.trk}) - tgt1;

	always_comb begin
		err = err_raw;
		if (err < -CRS_HALF) err = err + CRS_FULL;
		if (err > CRS_HALF) err = err - CRS_FULL;
	end

	// Stage 3.
	logic               vld_s3;
	logic signed [17:0] err_s3;
	sb_d_t              sb_d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= mag_vld;
		end
	end

	always_ff @(posedge clk) begin
		err_s3           <= err;
		sb_d_s3.tgt      <= tgt1[15:0];
		sb_d_s3.ctr_dist <= sb_c_o.ctr_dist;
		sb_d_s3.ttg      <= sb_c_o.ttg;
		sb_d_s3.ideal    <= sb_c_o.ideal;
		sb_d_s3.spd      <= sb_c_o.spd;
	end

	// Fold the error into -90..90 degrees for the sine.
	logic signed [17:0]      sin_ang;
	logic signed [ANG_W-1:0] sin_z0;
	logic                    sin_vld;
	logic signed [SIN_XW-1:0] sin_y;
	sb_d_t                   sb_d_o;

	always_comb begin
		sin_ang = err_s3;
		if (err_s3 > CRS_QTR) begin
			sin_ang = CRS_HALF - err_s3;
		end else if (err_s3 < -CRS_QTR) begin
			sin_ang = -CRS_HALF - err_s3;
		end
	end

	assign sin_z0 = ANG_W'(sin_ang) <<< 16;

	cog_cordic #(
		.XW(SIN_XW), .VECTORING(1'b0), .SW($bits(sb_d_t))
	) u_sin (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s3),
		.x_in    (SIN_XW'(SIN_X0)),
		.y_in    ('0),
		.z_in    (sin_z0),
		.side_in (sb_d_s3),
		.out_vld (sin_vld),
		.y_out   (sin_y),
		.z_out   (),
		.side_out(sb_d_o)
	);

	// Stage 4: sine times speed.
	logic               vld_s4;
	logic signed [38:0] a_s4;
	sb_e_t              sb_e_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sin_vld;
		end
	end

	always_ff @(posedge clk) begin
		a_s4             <= 39'(sin_y) * 39'($signed({1'b0, sb_d_o.spd}));
		sb_e_s4.tgt      <= sb_d_o.tgt;
		sb_e_s4.ctr_dist <= sb_d_o.ctr_dist;
		sb_e_s4.ttg      <= sb_d_o.ttg;
		sb_e_s4.ideal    <= sb_d_o.ideal;
	end

	// Stage 5: magnitude times the L1 gain as two partial products.
	logic [38:0] a_mag;
	logic        vld_s5;
	logic        neg_s5;
	logic [41:0] ph_s5;
	logic [40:0] pl_s5;
	sb_e_t       sb_e_s5;

	assign a_mag = a_s4[38] ? 39'(-a_s4) : a_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		neg_s5  <= a_s4[38];
		ph_s5   <= 42'(a_mag[34:17]) * 42'(L1_GAIN);
		pl_s5   <= 41'(a_mag[16:0]) * 41'(L1_GAIN);
		sb_e_s5 <= sb_e_s4;
	end

	// Stage 6: sum the partial products and drop the Q20 fraction.
	logic [58:0] l1_sum;
	logic        vld_s6;
	logic [38:0] l1_num_s6;
	sb_f_t       sb_f_s6;

	assign l1_sum = {ph_s5, 17'b0} + 59'(pl_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		l1_num_s6   <= l1_sum[58:20];
		sb_f_s6.neg <= neg_s5;
		sb_f_s6.e   <= sb_e_s5;
	end

	// L1 lateral acceleration magnitude over the period.
	logic             l1_vld;
	logic [L1_QW-1:0] l1_quo;
	sb_f_t            sb_f_o;

	cog_div #(
		.NW(39), .DW(16), .QW(L1_QW), .SW($bits(sb_f_t))
	) u_div_l1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s6),
		.num     (l1_num_s6),
		.den     (p_eff),
		.side_in (sb_f_s6),
		.out_vld (l1_vld),
		.quo     (l1_quo),
		.side_out(sb_f_o)
	);

	// Signed total lateral acceleration.
	logic signed [VEC_XW-1:0] l1_acc;
	logic signed [VEC_XW-1:0] ideal_acc;
	logic                     vld_s7;
	logic signed [VEC_XW-1:0] acc_s7;
	sb_g_t                    sb_g_s7;

	assign l1_acc    = sb_f_o.neg ? -VEC_XW'(l1_quo) : VEC_XW'(l1_quo);
	assign ideal_acc = turn_right_q ? -VEC_XW'(sb_f_o.e.ideal) : VEC_XW'(sb_f_o.e.ideal);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= l1_vld;
		end
	end

	always_ff @(posedge clk) begin
		acc_s7           <= l1_acc + ideal_acc;
		sb_g_s7.tgt      <= sb_f_o.e.tgt;
		sb_g_s7.ctr_dist <= sb_f_o.e.ctr_dist;
		sb_g_s7.ttg      <= sb_f_o.e.ttg;
	end

	// Bank angle from atan(a/g).
	logic                    vec_vld;
	logic signed [ANG_W-1:0] vec_z;
	sb_g_t                   sb_g_o;

	cog_cordic #(
		.XW(VEC_XW), .VECTORING(1'b1), .SW($bits(sb_g_t))
	) u_atan (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s7),
		.x_in    (VEC_XW'(GRAVITY_UM)),
		.y_in    (acc_s7),
		.z_in    ('0),
		.side_in (sb_g_s7),
		.out_vld (vec_vld),
		.y_out   (),
		.z_out   (vec_z),
		.side_out(sb_g_o)
	);

	// Round to centidegrees away from zero, negate and clamp.
	logic [ANG_W-1:0]   z_mag;
	logic [ANG_W:0]     z_rnd;
	logic signed [17:0] bank_raw;
	logic signed [17:0] lim_s;
	logic signed [17:0] bank;

	assign z_mag    = vec_z[ANG_W-1] ? ANG_W'(-vec_z) : vec_z;
	assign z_rnd    = {1'b0, z_mag} + (ANG_W+1)'(ANG_ROUND);
	assign lim_s    = $signed({4'b0, lim_eff});
	assign bank_raw = vec_z[ANG_W-1] ? $signed({1'b0, z_rnd[32:16]}) :
		-$signed({1'b0, z_rnd[32:16]});

	always_comb begin
		bank = bank_raw;
		if (bank < -lim_s) bank = -lim_s;
		if (bank > lim_s) bank = lim_s;
	end

	// Output registers.
	logic               done_q;
	logic [15:0]        course_q;
	logic signed [14:0] bank_q;
	logic [19:0]        dist_q;
	logic [19:0]        ttg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vec_vld;
		end
	end

	always_ff @(posedge clk) begin
		course_q <= sb_g_o.tgt;
		bank_q   <= 15'(bank);
		dist_q   <= sb_g_o.ctr_dist;
		ttg_q    <= sb_g_o.ttg;
	end

	assign done          = done_q;
	assign target_course = course_q;
	assign bank_cmd      = bank_q;
	assign distance_out  = dist_q;
	assign time_to_go    = ttg_q;

`ifndef SYNTH
	// Every result comes from the transaction accepted a fixed latency earlier.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching input transaction");

	// The commanded course stays within one turn.
	a_course: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> target_course <= 16'(COURSE_FULL))
		else $error("target course out of range");

	// The bank command respects the effective bank limit.
	a_bank: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bank_cmd <= $signed({1'b0, lim_eff}))
			&& (bank_cmd >= -$signed({1'b0, lim_eff})))
		else $error("bank command beyond limit");
`endif

endmodule

FILE: hw/rtl/cog_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Caller guarantees num >> QW is below den. No package dependencies.
`timescale 1ns / 1ps

module cog_div #(
	parameter int NW = 34,
	parameter int DW = 20,
	parameter int QW = 14,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [1:QW];
	logic [DW-1:0] rem_s  [1:QW];
	logic [QW-1:0] lo_s   [1:QW];
	logic [DW-1:0] den_s  [1:QW];
	logic [SW-1:0] side_s [1:QW];

	// Each stage shifts one numerator bit into the remainder and one quotient
	// bit into the low word.
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic          vld_p;
		logic [DW-1:0] rem_p;
		logic [QW-1:0] lo_p;
		logic [DW-1:0] den_p;
		logic [SW-1:0] side_p;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_in
			assign vld_p  = in_vld;
			assign rem_p  = DW'(num >> QW);
			assign lo_p   = num[QW-1:0];
			assign den_p  = den;
			assign side_p = side_in;
		end else begin : g_mid
			assign vld_p  = vld_s[k];
			assign rem_p  = rem_s[k];
			assign lo_p   = lo_s[k];
			assign den_p  = den_s[k];
			assign side_p = side_s[k];
		end

		assign trial = {rem_p, lo_p[QW-1]};
		assign ge    = trial >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
			lo_s[k+1]   <= {lo_p[QW-2:0], ge};
			den_s[k+1]  <= den_p;
			side_s[k+1] <= side_p;
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = lo_s[QW];
	assign side_out = side_s[QW];

endmodule

FILE: hw/rtl/cog_cordic.sv
// Pipelined CORDIC, one micro-rotation per register stage, in rotation or
// vectoring mode. Depends on cog_pkg for the arctangent table.
`timescale 1ns / 1ps

module cog_cordic #(
	parameter int XW        = 24,
	parameter bit VECTORING = 1'b0,
	parameter int SW        = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic signed [XW-1:0]           x_in,
	input  logic signed [XW-1:0]           y_in,
	input  logic signed [cog_pkg::ANG_W-1:0] z_in,
	input  logic [SW-1:0]                  side_in,
	output logic                           out_vld,
	output logic signed [XW-1:0]           y_out,
	output logic signed [cog_pkg::ANG_W-1:0] z_out,
	output logic [SW-1:0]                  side_out
);
	import cog_pkg::*;

	logic                    vld_s  [1:CORDIC_STEPS];
	logic signed [XW-1:0]    x_s    [1:CORDIC_STEPS];
	logic signed [XW-1:0]    y_s    [1:CORDIC_STEPS];
	logic signed [ANG_W-1:0] z_s    [1:CORDIC_STEPS];
	logic [SW-1:0]           side_s [1:CORDIC_STEPS];

	// One micro-rotation per stage; direction from the angle residue in
	// rotation mode and from the sign of y in vectoring mode.
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		logic                    vld_p;
		logic signed [XW-1:0]    x_p;
		logic signed [XW-1:0]    y_p;
		logic signed [ANG_W-1:0] z_p;
		logic [SW-1:0]           side_p;
		logic                    ccw;

		if (k == 0) begin : g_in
			assign vld_p  = in_vld;
			assign x_p    = x_in;
			assign y_p    = y_in;
			assign z_p    = z_in;
			assign side_p = side_in;
		end else begin : g_mid
			assign vld_p  = vld_s[k];
			assign x_p    = x_s[k];
			assign y_p    = y_s[k];
			assign z_p    = z_s[k];
			assign side_p = side_s[k];
		end

		assign ccw = VECTORING ? !(y_p > 0) : (z_p >= 0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (ccw) begin
				x_s[k+1] <= x_p - (y_p >>> k);
				y_s[k+1] <= y_p + (x_p >>> k);
				z_s[k+1] <= z_p - cog_atan(k);
			end else begin
				x_s[k+1] <= x_p + (y_p >>> k);
				y_s[k+1] <= y_p - (x_p >>> k);
				z_s[k+1] <= z_p + cog_atan(k);
			end
			side_s[k+1] <= side_p;
		end
	end

	assign out_vld  = vld_s[CORDIC_STEPS];
	assign y_out    = y_s[CORDIC_STEPS];
	assign z_out    = z_s[CORDIC_STEPS];
	assign side_out = side_s[CORDIC_STEPS];

endmodule
